/* hw/rtl/fbr_pkg.sv */
package fbr_pkg;

   // Default sizes of the weight and bias stores.
   localparam int MAX_INNER_DEF   = 64;
   localparam int MAX_COLUMNS_DEF = 32;

   // Fixed field widths.
   localparam int OP_W     = 2;
   localparam int INNER_W  = 6;
   localparam int COL_W    = 5;
   localparam int VAL_W    = 16;
   localparam int RES_W    = 15;
   localparam int ISIZE_W  = 7;
   localparam int OSIZE_W  = 6;
   localparam int ACC_W    = 40;
   localparam int PROD_W   = 2 * VAL_W;
   localparam int SUM_W    = ACC_W + 1;
   localparam int ADDR_W   = 3;
   localparam int DATA_W   = 32;

   localparam logic [ISIZE_W-1:0] INNER_SIZE_RST = ISIZE_W'(64);
   localparam logic [OSIZE_W-1:0] OUT_SIZE_RST   = OSIZE_W'(32);

   // Register select, taken from paddr bit 2.
   localparam logic REG_INNER_SIZE = 1'b0;
   localparam logic REG_OUT_SIZE   = 1'b1;

   localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

   typedef enum logic [OP_W-1:0] {
      OP_BIAS   = 2'd0,
      OP_WEIGHT = 2'd1,
      OP_ACT    = 2'd2
   } op_type;

   // Word that travels down the cell chain.
   typedef struct packed {
      logic                    valid;
      op_type                  op;
      logic [INNER_W-1:0]      k;
      logic [COL_W-1:0]        col;
      logic signed [VAL_W-1:0] value;
      logic                    act;   // activation inside the row
      logic                    fin;   // activation with the final inner index
   } tok_type;

   typedef struct packed {
      logic [COL_W-1:0] column;
      logic [RES_W-1:0] result;
      logic             last;
   } res_type;

   // Result lane between cells.
   typedef struct packed {
      logic    valid;
      res_type res;
   } lane_type;

endpackage

/* hw/rtl/fbr_req_if.sv */
interface fbr_req_if import fbr_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [OP_W-1:0]         operation;
   logic [INNER_W-1:0]      inner_index;
   logic [COL_W-1:0]        column_index;
   logic signed [VAL_W-1:0] value;

   modport source (output valid, operation, inner_index, column_index, value, input ready);
   modport sink   (input valid, operation, inner_index, column_index, value, output ready);
endinterface

/* hw/rtl/fbr_rsp_if.sv */
interface fbr_rsp_if import fbr_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [COL_W-1:0] column;
   logic [RES_W-1:0] result;
   logic             last;

   modport source (output valid, column, result, last, input ready);
   modport sink   (input valid, column, result, last, output ready);
endinterface

/* hw/rtl/fbr_cell.sv */
module fbr_cell import fbr_pkg::*; #(
   parameter int MAX_INNER   = MAX_INNER_DEF,
   parameter int MAX_COLUMNS = MAX_COLUMNS_DEF,
   parameter int COL_ID      = 0,
   localparam int NN_W       = $clog2(MAX_COLUMNS + 1),
   localparam int IW         = (MAX_INNER > 1) ? $clog2(MAX_INNER) : 1
) (
   input  logic            clock,
   input  logic            reset,
   input  logic [NN_W-1:0] nn,
   input  tok_type         prev_tok,
   output tok_type         next_tok,
   input  lane_type        prev_lane,
   output lane_type        next_lane
);

   logic [VAL_W-1:0]        wmem [MAX_INNER];
   logic signed [VAL_W-1:0] rdata_ff;
   logic signed [VAL_W-1:0] bias_ff;
   tok_type                 s0_ff;
   tok_type                 s1_ff;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic signed [SUM_W-1:0] acc_sum;
   logic signed [SUM_W-1:0] sum_ff, sum_in;
   logic                    emit2_ff, emit2_in;
   logic                    emit3_ff;
   lane_type                lane_ff, lane_in;
   logic                    hit;
   logic                    col_on;
   logic                    mac;
   logic [SUM_W-1:0]        rnd;
   logic [RES_W-1:0]        res_val;

   assign hit    = prev_tok.valid && (int'(prev_tok.col) == COL_ID);
   assign col_on = COL_ID < int'(nn);

   // Weight column of this cell: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (hit && prev_tok.op == OP_WEIGHT && int'(prev_tok.k) < MAX_INNER) begin
         wmem[IW'(prev_tok.k)] <= prev_tok.value;
      end
      rdata_ff <= wmem[IW'(prev_tok.k)];
   end

   always_ff @(posedge clock) begin
      if (hit && prev_tok.op == OP_BIAS) begin
         bias_ff <= prev_tok.value;
      end
   end

   assign prod_in = s0_ff.value * rdata_ff;
   assign mac     = s1_ff.valid && s1_ff.act && col_on;
   assign acc_sum = SUM_W'(acc_ff) + SUM_W'(prod_ff);

   always_comb begin
      if (emit2_ff) begin
         acc_in = '0;
      end else if (mac) begin
         if (acc_sum[SUM_W-1] != acc_sum[SUM_W-2]) begin
            acc_in = acc_sum[SUM_W-1] ? ACC_MIN : ACC_MAX;
         end else begin
            acc_in = acc_sum[ACC_W-1:0];
         end
      end else begin
         acc_in = acc_ff;
      end
   end

   // The end of a row clears the sum in every cell, including the inactive ones.
   assign emit2_in = s1_ff.valid && s1_ff.fin;
   assign sum_in   = SUM_W'(acc_ff) + (SUM_W'(bias_ff) <<< 8);

   // Round the Q.16 sum to unsigned Q7.8, clip negatives to zero and saturate the top.
   always_comb begin
      rnd = unsigned'(sum_ff) + SUM_W'(128);
      if (sum_ff[SUM_W-1] || sum_ff == '0) begin
         res_val = '0;
      end else if (|rnd[SUM_W-1:RES_W+8]) begin
         res_val = '1;
      end else begin
         res_val = rnd[RES_W+7:8];
      end
   end

   always_comb begin
      if (emit3_ff && col_on) begin
         lane_in.valid      = 1'b1;
         lane_in.res.column = COL_W'(COL_ID);
         lane_in.res.result = res_val;
         lane_in.res.last   = (COL_ID == int'(nn) - 1);
      end else begin
         lane_in = prev_lane;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_ff.valid   <= 1'b0;
         s1_ff.valid   <= 1'b0;
         emit2_ff      <= 1'b0;
         emit3_ff      <= 1'b0;
         lane_ff.valid <= 1'b0;
         acc_ff        <= '0;
      end else begin
         s0_ff    <= prev_tok;
         s1_ff    <= s0_ff;
         emit2_ff <= emit2_in;
         emit3_ff <= emit2_ff;
         lane_ff  <= lane_in;
         acc_ff   <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      sum_ff  <= sum_in;
   end

   // A word passes the s0_ff and s1_ff registers of each cell while a result passes only lane_ff,
   // so results of successive columns reach the end of the lane on successive cycles without meeting.
   assign next_tok  = s1_ff;
   assign next_lane = lane_ff;

endmodule

/* hw/rtl/fbr_out_fifo.sv */
module fbr_out_fifo import fbr_pkg::*; #(
   parameter int DEPTH = 2 * MAX_COLUMNS_DEF,
   localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int LW   = $clog2(DEPTH + 1)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  res_type       push_data,
   output logic          out_valid,
   input  logic          out_ready,
   output res_type       out_data,
   output logic [LW-1:0] level
);

   res_type       mem [DEPTH];
   logic [PW-1:0] wr_ff, wr_in;
   logic [PW-1:0] rd_ff, rd_in;
   logic [LW-1:0] cnt_ff, cnt_in;
   logic          ov_ff, ov_in;
   res_type       out_ff;
   logic          load;

   assign load = (cnt_ff != '0) && (!ov_ff || out_ready);

   always_comb begin
      wr_in = wr_ff;
      rd_in = rd_ff;
      if (push) begin
         wr_in = (wr_ff == PW'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (load) begin
         rd_in = (rd_ff == PW'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      cnt_in = cnt_ff + LW'(push) - LW'(load);
      if (load) begin
         ov_in = 1'b1;
      end else if (out_ready) begin
         ov_in = 1'b0;
      end else begin
         ov_in = ov_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ff] <= push_data;
      end
      if (load) begin
         out_ff <= mem[rd_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
         ov_ff  <= 1'b0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
         ov_ff  <= ov_in;
      end
   end

   assign out_valid = ov_ff;
   assign out_data  = out_ff;
   assign level     = cnt_ff;

endmodule

/* hw/rtl/fused_linear_bias_relu.sv */
// Fully connected layer with bias and ReLU in Q8.8: a word on req_chan writes a bias
// (operation 0) or a weight (operation 1) into the cell of its column, or streams one
// activation (operation 2) that every active column cell multiplies by its weight and adds
// to its 40-bit saturating accumulator. The activation whose inner index is inner_size-1
// makes each of the first out_size columns send one result, in column order, on rsp_chan.
// A chain of MAX_COLUMNS cells does the work; each cell owns one weight column memory,
// its bias and its accumulator; words pass the s0_ff and s1_ff registers of each cell.
// Writes and activations not ending a row are taken one per cycle while ready is high.
// After the final activation of a row, req_chan.ready stays low while the word walks the
// chain and the results drain into a 2*MAX_COLUMNS-entry output queue; ready is also low
// while that queue has fewer than MAX_COLUMNS free entries. Results leave on rsp_chan one
// per cycle while rsp_chan.ready is high. inner_size and out_size are written at byte
// addresses 0 and 4, by the user only while idle; the block itself does not enforce it.
module fused_linear_bias_relu import fbr_pkg::*; #(
   parameter int MAX_INNER   = MAX_INNER_DEF,
   parameter int MAX_COLUMNS = MAX_COLUMNS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   fbr_req_if.sink           req_chan,
   fbr_rsp_if.source         rsp_chan,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [ADDR_W-1:0] csr_paddr,
   input  logic [DATA_W-1:0] csr_pwdata,
   output logic [DATA_W-1:0] csr_prdata,
   output logic              csr_pready
);

   localparam int FD   = 2 * MAX_COLUMNS;
   localparam int LW   = $clog2(FD + 1);
   localparam int NN_W = $clog2(MAX_COLUMNS + 1);
   localparam int KN_W = $clog2(MAX_INNER + 1);
   localparam int COOL = 2 * MAX_COLUMNS + 4;
   localparam int CW   = $clog2(COOL + 1);

   logic [ISIZE_W-1:0] inner_size_ff, inner_size_in;
   logic [OSIZE_W-1:0] out_size_ff, out_size_in;
   logic               csr_wr;
   logic [KN_W-1:0]    kn;
   logic [NN_W-1:0]    nn;
   logic [CW-1:0]      cool_ff, cool_in;
   logic [LW-1:0]      level;
   logic               req_rdy;
   logic               accept;
   tok_type            tok_ff, tok_in;
   tok_type            tok_chain  [MAX_COLUMNS+1];
   lane_type           lane_chain [MAX_COLUMNS+1];
   lane_type           lane_end;
   res_type            out_data;

   // Configuration registers.
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      inner_size_in = inner_size_ff;
      out_size_in   = out_size_ff;
      if (csr_wr) begin
         case (csr_paddr[2])
            REG_INNER_SIZE: inner_size_in = csr_pwdata[ISIZE_W-1:0];
            REG_OUT_SIZE:   out_size_in   = csr_pwdata[OSIZE_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[2])
         REG_INNER_SIZE: csr_prdata = DATA_W'(inner_size_ff);
         REG_OUT_SIZE:   csr_prdata = DATA_W'(out_size_ff);
         default:        csr_prdata = '0;
      endcase
   end

   // Sizes clamped to the store dimensions.
   always_comb begin
      if (inner_size_ff == '0) begin
         kn = KN_W'(1);
      end else if (int'(inner_size_ff) > MAX_INNER) begin
         kn = KN_W'(MAX_INNER);
      end else begin
         kn = KN_W'(inner_size_ff);
      end
      if (out_size_ff == '0) begin
         nn = NN_W'(1);
      end else if (int'(out_size_ff) > MAX_COLUMNS) begin
         nn = NN_W'(MAX_COLUMNS);
      end else begin
         nn = NN_W'(out_size_ff);
      end
   end

   assign req_rdy        = (cool_ff == '0) && (level <= LW'(FD - MAX_COLUMNS));
   assign req_chan.ready = req_rdy;
   assign accept         = req_chan.valid && req_rdy;

   always_comb begin
      tok_in.valid = accept;
      tok_in.op    = op_type'(req_chan.operation);
      tok_in.k     = req_chan.inner_index;
      tok_in.col   = req_chan.column_index;
      tok_in.value = req_chan.value;
      tok_in.act   = (tok_in.op == OP_ACT) && (int'(req_chan.inner_index) < int'(kn));
      tok_in.fin   = tok_in.act && (int'(req_chan.inner_index) == int'(kn) - 1);
   end

   always_comb begin
      if (accept && tok_in.fin) begin
         cool_in = CW'(COOL);
      end else if (cool_ff != '0) begin
         cool_in = cool_ff - 1'b1;
      end else begin
         cool_in = cool_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inner_size_ff <= INNER_SIZE_RST;
         out_size_ff   <= OUT_SIZE_RST;
         cool_ff       <= '0;
         tok_ff.valid  <= 1'b0;
      end else begin
         inner_size_ff <= inner_size_in;
         out_size_ff   <= out_size_in;
         cool_ff       <= cool_in;
         tok_ff        <= tok_in;
      end
   end

   assign tok_chain[0]  = tok_ff;
   assign lane_chain[0] = '0;

   for (genvar j = 0; j < MAX_COLUMNS; j++) begin : g_cell
      fbr_cell #(
         .MAX_INNER   (MAX_INNER),
         .MAX_COLUMNS (MAX_COLUMNS),
         .COL_ID      (j)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .nn        (nn),
         .prev_tok  (tok_chain[j]),
         .next_tok  (tok_chain[j+1]),
         .prev_lane (lane_chain[j]),
         .next_lane (lane_chain[j+1])
      );
   end

   assign lane_end = lane_chain[MAX_COLUMNS];

   fbr_out_fifo #(
      .DEPTH (FD)
   ) u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (lane_end.valid),
      .push_data (lane_end.res),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .out_data  (out_data),
      .level     (level)
   );

   assign rsp_chan.column = out_data.column;
   assign rsp_chan.result = out_data.result;
   assign rsp_chan.last   = out_data.last;

   // The queue always has room when a result leaves the chain.
   a_queue_room: assert property (@(posedge clock) disable iff (reset)
      lane_end.valid |-> (level < LW'(FD)))
      else $error("result left the cell chain with the output queue full");

   // Results of one row leave the chain on consecutive cycles.
   a_row_contiguous: assert property (@(posedge clock) disable iff (reset)
      (lane_end.valid && !lane_end.res.last) |=> lane_end.valid)
      else $error("gap inside a row of results");

   // ... and in increasing column order.
   a_column_order: assert property (@(posedge clock) disable iff (reset)
      (lane_end.valid && $past(lane_end.valid) && !$past(lane_end.res.last)) |->
         (lane_end.res.column == COL_W'($past(lane_end.res.column) + 1'b1)))
      else $error("results out of column order");

endmodule
